/* src/plcs_pkg.sv */
// Package for the PWM LED column serializer.
// Holds sizes, register indexes, the row cell control struct and the pixel evaluation.
// No dependencies.
`default_nettype none

package plcs_pkg;

    // Column geometry
    localparam int ROWS      = 10;
    localparam int COLORS    = 3;
    localparam int WORD_BITS = 32;
    localparam int COUNT_W   = $clog2(WORD_BITS);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PWM_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_FOR_ZERO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_FOR_ONE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_FOR_TWO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_FOR_THREE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_COLUMNS = 3'd5;

    // Intensity to on-duration table, entry i for 2-bit intensity i
    typedef logic [3:0][7:0] level_table_t;

    // Control broadcast to every row cell
    typedef struct packed {
        logic              step;   // a pixel request is taken this cycle
        logic              flush;  // that request closes the column
        logic [COLORS-1:0] bits;   // on/off bits of the pixel, red at bit 0
    } cell_ctrl_t;

    // On/off bits of one pixel, colour c at bit c (red, green, blue)
    function automatic logic [COLORS-1:0] pixel_on_bits(
        input logic [5:0]   color,
        input logic [7:0]   slice,
        input logic [7:0]   column,
        input logic         pwm,
        input level_table_t levels,
        input logic [7:0]   visible
    );
        logic [COLORS-1:0] result;
        logic [1:0]        intensity;
        result = '0;
        for (int c = 0; c < COLORS; c++)
        begin
            intensity = color[5 - 2*c -: 2];
            if (pwm)
                result[c] = levels[intensity] > slice;
            else
                result[c] = intensity != 2'd0;
        end
        if (column >= visible)
            result = '0;
        return result;
    endfunction

endpackage

`default_nettype wire

/* src/plcs_ifs.sv */
// Handshake channels of the PWM LED column serializer.
// Pixel request channel and serial bit channel; no dependencies.
`default_nettype none

interface plcs_pixel_if;
    logic       valid;
    logic       ready;
    logic [5:0] pixel_color;
    logic [7:0] time_slice;
    logic [7:0] column_index;
    logic       last_of_column;

    modport source (output valid, pixel_color, time_slice, column_index, last_of_column,
                    input ready);
    modport sink   (input valid, pixel_color, time_slice, column_index, last_of_column,
                    output ready);
endinterface

interface plcs_bit_if;
    logic valid;
    logic ready;
    logic serial_bit;
    logic latch_strobe;

    modport source (output valid, serial_bit, latch_strobe, input ready);
    modport sink   (input valid, serial_bit, latch_strobe, output ready);
endinterface

`default_nettype wire

/* src/plcs_row_cell.sv */
// One row cell: holds the three colour bits of its row and a filled flag.
// The filled flag is handed to the next cell; uses plcs_pkg.
`default_nettype none

module plcs_row_cell (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire plcs_pkg::cell_ctrl_t         ctrl,
    input  wire logic                         prev_filled,
    output logic                              filled,
    output logic                              current,
    output logic [plcs_pkg::COLORS-1:0]       cell_bits
);

    logic                          filled_reg;
    logic                          filled_next;
    logic [plcs_pkg::COLORS-1:0]   bits_reg;
    logic [plcs_pkg::COLORS-1:0]   bits_next;

    // This cell takes the next pixel when its predecessor is filled and it is not
    assign current = prev_filled & ~filled_reg;
    assign filled  = filled_reg;

    // Row bits as seen by a flush, including a pixel landing this cycle
    assign cell_bits = bits_reg | (current ? ctrl.bits : '0);

    always_comb
    begin
        filled_next = filled_reg;
        bits_next   = bits_reg;
        if (ctrl.flush)
        begin
            filled_next = 1'b0;
            bits_next   = '0;
        end
        else if (ctrl.step && current)
        begin
            filled_next = 1'b1;
            bits_next   = ctrl.bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= 1'b0;
            bits_reg   <= '0;
        end
        else
        begin
            filled_reg <= filled_next;
            bits_reg   <= bits_next;
        end
    end

endmodule

`default_nettype wire

/* src/plcs_serializer.sv */
// Column word buffer and MSB-first shifter with latch strobe on the last bit.
// Uses plcs_pkg and plcs_bit_if.
`default_nettype none

module plcs_serializer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            capture,
    input  wire logic [plcs_pkg::WORD_BITS-1:0]  word,
    output logic                                 pend_full,
    output logic                                 pend_take,
    plcs_bit_if.source                           serial
);

    localparam logic [plcs_pkg::COUNT_W-1:0] LAST_BIT =
        plcs_pkg::COUNT_W'(plcs_pkg::WORD_BITS - 1);

    logic [plcs_pkg::WORD_BITS-1:0] pend_word_reg;
    logic                           pend_valid_reg;
    logic                           pend_valid_next;
    logic [plcs_pkg::WORD_BITS-1:0] shift_reg;
    logic [plcs_pkg::WORD_BITS-1:0] shift_next;
    logic [plcs_pkg::COUNT_W-1:0]   count_reg;
    logic [plcs_pkg::COUNT_W-1:0]   count_next;
    logic                           active_reg;
    logic                           active_next;
    logic                           finishing;
    logic                           load;

    assign pend_full          = pend_valid_reg;
    assign pend_take          = load;
    assign serial.valid       = active_reg;
    assign serial.serial_bit  = shift_reg[plcs_pkg::WORD_BITS-1];
    assign serial.latch_strobe = count_reg == LAST_BIT;

    // Last bit leaves this cycle; a waiting word may follow straight on
    assign finishing = active_reg & serial.ready & (count_reg == LAST_BIT);
    assign load      = pend_valid_reg & (~active_reg | finishing);

    always_comb
    begin
        shift_next  = shift_reg;
        count_next  = count_reg;
        active_next = active_reg;
        if (load)
        begin
            shift_next  = pend_word_reg;
            count_next  = '0;
            active_next = 1'b1;
        end
        else if (active_reg && serial.ready)
        begin
            shift_next  = {shift_reg[plcs_pkg::WORD_BITS-2:0], 1'b0};
            count_next  = count_reg + 1'b1;
            active_next = ~finishing;
        end
    end

    // Pending slot: filled by a closing pixel, emptied into the shifter
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (load)
            pend_valid_next = 1'b0;
        if (capture)
            pend_valid_next = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (capture)
            pend_word_reg <= word;
        shift_reg <= shift_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
            active_reg     <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
            active_reg     <= active_next;
        end
    end

endmodule

`default_nettype wire

/* src/pwm_led_column_serializer_core.sv */
// Top level of the PWM LED column serializer.
// Uses plcs_pkg, plcs_ifs, plcs_row_cell and plcs_serializer.
//
//  channel   | dir | request                                              | handshake
//  ----------+-----+------------------------------------------------------+-----------
//  pixels    | in  | pixel_color, time_slice, column_index, last_of_column | valid/ready
//  serial    | out | serial_bit, latch_strobe                              | valid/ready
//  cfg       | in  | cfg_index, cfg_data                                   | cfg_we only
//
// One pixel request is taken every cycle unless stalled; the row cells build the column
// word in place. A closing pixel moves the word to a one-deep buffer; the shifter sends
// 32 bits, one a cycle while serial ready is high. Pixels stall only while that buffer
// holds a word behind the one being shifted out.
// Reset clears the cells, the buffer and the shifter and restores the register defaults.
`default_nettype none

module pwm_led_column_serializer_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    plcs_pixel_if.sink                             pixels,
    plcs_bit_if.source                             serial,
    input  wire logic                              cfg_we,
    input  wire logic [plcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [plcs_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic                           pwm_enable_reg;
    plcs_pkg::level_table_t         levels_reg;
    logic [7:0]                     visible_reg;
    plcs_pkg::cell_ctrl_t           ctrl;
    logic                           accept;
    logic                           pend_full;
    logic                           pend_take;
    logic [plcs_pkg::ROWS-1:0]      filled;
    logic [plcs_pkg::ROWS-1:0]      current;
    logic [plcs_pkg::ROWS-1:0][plcs_pkg::COLORS-1:0] row_bits;
    logic [plcs_pkg::WORD_BITS-1:0] word;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_enable_reg <= 1'b1;
            levels_reg[0]  <= 8'd0;
            levels_reg[1]  <= 8'd1;
            levels_reg[2]  <= 8'd2;
            levels_reg[3]  <= 8'd3;
            visible_reg    <= 8'd255;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                plcs_pkg::CFG_PWM_ENABLE:      pwm_enable_reg <= cfg_data[0];
                plcs_pkg::CFG_LEVEL_FOR_ZERO:  levels_reg[0]  <= cfg_data;
                plcs_pkg::CFG_LEVEL_FOR_ONE:   levels_reg[1]  <= cfg_data;
                plcs_pkg::CFG_LEVEL_FOR_TWO:   levels_reg[2]  <= cfg_data;
                plcs_pkg::CFG_LEVEL_FOR_THREE: levels_reg[3]  <= cfg_data;
                plcs_pkg::CFG_VISIBLE_COLUMNS: visible_reg    <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // Pixel intake and cell control; the buffer can take a word in the cycle it empties
    assign pixels.ready = ~pend_full | pend_take;
    assign accept       = pixels.valid & pixels.ready;
    assign ctrl.step    = accept;
    assign ctrl.flush   = accept & pixels.last_of_column;
    assign ctrl.bits    = plcs_pkg::pixel_on_bits(pixels.pixel_color, pixels.time_slice,
                                                  pixels.column_index, pwm_enable_reg,
                                                  levels_reg, visible_reg);

    // Chain of row cells, the filled flag passed down the row
    for (genvar r = 0; r < plcs_pkg::ROWS; r++)
    begin : g_row
        logic prev_filled;
        if (r == 0)
        begin : g_head
            assign prev_filled = 1'b1;
        end
        else
        begin : g_tail
            assign prev_filled = filled[r-1];
        end

        plcs_row_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .prev_filled (prev_filled),
            .filled      (filled[r]),
            .current     (current[r]),
            .cell_bits   (row_bits[r])
        );
    end

    // Column word: row r at bits 3r+2..3r, top bits zero
    always_comb
    begin
        word = '0;
        for (int r = 0; r < plcs_pkg::ROWS; r++)
            word[r*plcs_pkg::COLORS +: plcs_pkg::COLORS] = row_bits[r];
    end

    plcs_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .capture   (ctrl.flush),
        .word      (word),
        .pend_full (pend_full),
        .pend_take (pend_take),
        .serial    (serial)
    );

    // Checks
    a_one_current_row: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(current))
        else $error("more than one row cell takes the next pixel");

    a_close_fills_buffer: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.flush |=> pend_full)
        else $error("closing pixel did not reach the column buffer");

    a_close_clears_row: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.flush |=> (filled == '0))
        else $error("row cells not cleared after closing pixel");

    a_strobe_ends_word: assert property (@(posedge clk) disable iff (!rst_n)
        (serial.valid && serial.ready && serial.latch_strobe && !pend_full) |=> !serial.valid)
        else $error("shifter kept running after the latch bit with no word waiting");

endmodule

`default_nettype wire

/* tb/tb_pwm_led_column_serializer_core.sv */
// Self-checking bench for the PWM LED column serializer core.
// Predicts the 32-bit serial stream of every closed column and checks it bit by bit.
// Depends on plcs_pkg, plcs_ifs and pwm_led_column_serializer_core.
`default_nettype none

module tb_pwm_led_column_serializer_core;

    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLDOFF_CYCLES = 150;
    localparam int PHASES         = 6;

    // One pixel request as offered on the input channel
    typedef struct packed {
        logic [5:0] color;
        logic [7:0] slice;
        logic [7:0] column;
        logic       last;
    } pixel_t;

    // One serial request as seen on the output channel
    typedef struct packed {
        logic serial_bit;
        logic latch_strobe;
    } serial_bit_t;

    // Register contents as last written
    typedef struct packed {
        logic                   pwm;
        plcs_pkg::level_table_t levels;
        logic [7:0]             visible;
    } led_settings_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [plcs_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [plcs_pkg::CFG_DATA_W-1:0] cfg_data;

    plcs_pixel_if pixels_ch ();
    plcs_bit_if   serial_ch ();

    pwm_led_column_serializer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pixels_ch),
        .serial    (serial_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pixel_t        pending_pixels[$];
    serial_bit_t   expected_bits[$];
    led_settings_t active_settings;
    logic [31:0]   column_image;
    int            rows_taken;
    int            fail_count;
    int            sender_idle_pct;
    int            receiver_idle_pct;
    int            holdoff_left;
    logic          holdoff_request;
    pixel_t        offered_pixel;
    serial_bit_t   expected_bit;

    // Clock
    always #6 clk = ~clk;

    // Fold one accepted pixel into the column image; a closing pixel yields 32 bits
    task automatic absorb_pixel(input pixel_t px);
        logic [1:0] intensity;
        logic       lit;
        int         c;
        int         n;
        if (rows_taken < plcs_pkg::ROWS)
        begin
            if (px.column < active_settings.visible)
            begin
                for (c = 0; c < plcs_pkg::COLORS; c++)
                begin
                    intensity = px.color[5 - 2*c -: 2];
                    if (active_settings.pwm)
                        lit = active_settings.levels[intensity] > px.slice;
                    else
                        lit = intensity != 2'd0;
                    if (lit)
                        column_image[rows_taken*plcs_pkg::COLORS + c] = 1'b1;
                end
            end
            rows_taken++;
        end
        if (px.last)
        begin
            // MSB first, strobe on bit 0
            for (n = plcs_pkg::WORD_BITS - 1; n >= 0; n--)
                expected_bits.push_back('{serial_bit: column_image[n],
                                          latch_strobe: (n == 0)});
            column_image = '0;
            rows_taken   = 0;
        end
    endtask

    task automatic queue_pixel(input logic [5:0] color, input logic [7:0] slice,
                               input logic [7:0] column, input logic last);
        pending_pixels.push_back('{color: color, slice: slice, column: column, last: last});
    endtask

    // Random columns; mostly well formed, some overlong, scattered or left open
    task automatic queue_random_columns(input int count);
        int         k;
        int         r;
        int         rows;
        logic [7:0] column;
        logic [7:0] slice;
        bit         closed;
        bit         scatter;
        for (k = 0; k < count; k++)
        begin
            rows = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 14) : $urandom_range(1, 10);
            case ($urandom_range(0, 3))
                0, 1:    column = 8'($urandom_range(0, 255));
                2:       column = active_settings.visible - 8'd1;
                default: column = active_settings.visible;
            endcase
            if ($urandom_range(0, 3) == 0)
                slice = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            else
                slice = 8'($urandom_range(0, 255));
            closed  = (k == count - 1) || ($urandom_range(0, 9) != 0);
            scatter = $urandom_range(0, 6) == 0;
            for (r = 0; r < rows; r++)
                queue_pixel(6'($urandom_range(0, 63)),
                            scatter ? 8'($urandom_range(0, 255)) : slice,
                            scatter ? 8'($urandom_range(0, 255)) : column,
                            closed && (r == rows - 1));
        end
    endtask

    // Write every register, one per cycle
    task automatic apply_settings(input led_settings_t s);
        active_settings = s;
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= plcs_pkg::CFG_PWM_ENABLE;
        cfg_data  <= {{(plcs_pkg::CFG_DATA_W-1){1'b0}}, s.pwm};
        @(posedge clk);
        cfg_index <= plcs_pkg::CFG_LEVEL_FOR_ZERO;
        cfg_data  <= s.levels[0];
        @(posedge clk);
        cfg_index <= plcs_pkg::CFG_LEVEL_FOR_ONE;
        cfg_data  <= s.levels[1];
        @(posedge clk);
        cfg_index <= plcs_pkg::CFG_LEVEL_FOR_TWO;
        cfg_data  <= s.levels[2];
        @(posedge clk);
        cfg_index <= plcs_pkg::CFG_LEVEL_FOR_THREE;
        cfg_data  <= s.levels[3];
        @(posedge clk);
        cfg_index <= plcs_pkg::CFG_VISIBLE_COLUMNS;
        cfg_data  <= s.visible;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Wait until every pixel is taken and every bit has come out, then let the core settle
    task automatic drain_and_settle();
        while (pending_pixels.size() != 0 || pixels_ch.valid || expected_bits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Pixel driver: hold a request until taken, idle at random between requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixels_ch.valid          <= 1'b0;
            pixels_ch.pixel_color    <= '0;
            pixels_ch.time_slice     <= '0;
            pixels_ch.column_index   <= '0;
            pixels_ch.last_of_column <= 1'b0;
        end
        else if (!pixels_ch.valid || pixels_ch.ready)
        begin
            if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                offered_pixel             = pending_pixels.pop_front();
                pixels_ch.valid          <= 1'b1;
                pixels_ch.pixel_color    <= offered_pixel.color;
                pixels_ch.time_slice     <= offered_pixel.slice;
                pixels_ch.column_index   <= offered_pixel.column;
                pixels_ch.last_of_column <= offered_pixel.last;
            end
            else
                pixels_ch.valid <= 1'b0;
        end
    end

    // Pixel monitor: predict from each accepted request
    always @(posedge clk)
    begin
        if (rst_n && pixels_ch.valid && pixels_ch.ready)
            absorb_pixel('{color: pixels_ch.pixel_color, slice: pixels_ch.time_slice,
                           column: pixels_ch.column_index, last: pixels_ch.last_of_column});
    end

    // Long receiver hold-off, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            holdoff_left <= 0;
        else if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
        else if (holdoff_request)
            holdoff_left <= HOLDOFF_CYCLES;
    end

    // Serial receiver: random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            serial_ch.ready <= 1'b0;
        else if (holdoff_left != 0)
            serial_ch.ready <= 1'b0;
        else
            serial_ch.ready <= $urandom_range(0, 99) >= receiver_idle_pct;
    end

    // Serial monitor: compare against the oldest expected bit
    always @(posedge clk)
    begin
        if (rst_n && serial_ch.valid && serial_ch.ready)
        begin
            if (expected_bits.size() == 0)
            begin
                $error("serial request with no bit expected");
                fail_count++;
            end
            else
            begin
                expected_bit = expected_bits.pop_front();
                if (serial_ch.serial_bit !== expected_bit.serial_bit)
                begin
                    $error("serial_bit: expected %0b, got %0b",
                           expected_bit.serial_bit, serial_ch.serial_bit);
                    fail_count++;
                end
                if (serial_ch.latch_strobe !== expected_bit.latch_strobe)
                begin
                    $error("latch_strobe: expected %0b, got %0b",
                           expected_bit.latch_strobe, serial_ch.latch_strobe);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus and phase sequencing
    initial
    begin
        led_settings_t s;
        logic [5:0]    palette [10];
        int            i;
        int            p;

        clk                      = 1'b0;
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_index                = '0;
        cfg_data                 = '0;
        holdoff_request          = 1'b0;
        pixels_ch.valid          = 1'b0;
        pixels_ch.pixel_color    = '0;
        pixels_ch.time_slice     = '0;
        pixels_ch.column_index   = '0;
        pixels_ch.last_of_column = 1'b0;
        serial_ch.ready          = 1'b0;
        column_image             = '0;
        rows_taken               = 0;
        fail_count               = 0;
        sender_idle_pct          = 23;
        receiver_idle_pct        = 81;

        // Register defaults after reset
        active_settings.pwm       = 1'b1;
        active_settings.levels[0] = 8'd0;
        active_settings.levels[1] = 8'd1;
        active_settings.levels[2] = 8'd2;
        active_settings.levels[3] = 8'd3;
        active_settings.visible   = 8'd255;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Full column of ten rows, slices 0, 2 and 255 in turn
        palette = '{6'h3F, 6'h00, 6'h15, 6'h2A, 6'h30, 6'h0C, 6'h03, 6'h3F, 6'h24, 6'h3F};
        for (i = 0; i < plcs_pkg::ROWS; i++)
            queue_pixel(palette[i], (i % 3 == 0) ? 8'd0 : ((i % 3 == 1) ? 8'd2 : 8'd255),
                        8'd0, i == plcs_pkg::ROWS - 1);
        // Column out of view: bits stay dark
        for (i = 0; i < 3; i++)
            queue_pixel(6'h3F, 8'd0, 8'd255, i == 2);
        // Too many rows: the eleventh pixel, which closes the column, adds nothing
        for (i = 0; i < plcs_pkg::ROWS + 1; i++)
            queue_pixel(6'h3F, 8'd0, 8'd254, i == plcs_pkg::ROWS);
        // Single-pixel column
        queue_pixel(6'h3F, 8'd0, 8'd0, 1'b1);
        drain_and_settle();

        for (p = 0; p < PHASES; p++)
        begin
            if (p == 2)
            begin
                sender_idle_pct   = 81;
                receiver_idle_pct = 23;
            end
            else if (p == 4)
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            s.pwm = 1'b1;
            for (i = 0; i < 4; i++)
                s.levels[i] = 8'($urandom_range(0, 255));
            s.visible = 8'($urandom_range(100, 255));
            case (p)
                1:
                begin
                    s.pwm     = 1'b0;
                    s.visible = 8'd255;
                end
                2:
                begin
                    s.levels  = {8'd0, 8'd255, 8'd0, 8'd255};
                    s.visible = 8'd128;
                end
                3:
                begin
                    s.pwm     = 1'b0;
                    s.levels  = {4{8'd255}};
                    s.visible = 8'd0;
                end
                5:
                begin
                    s.levels  = {4{8'd255}};
                    s.visible = 8'd1;
                end
                default: ;
            endcase
            apply_settings(s);
            queue_random_columns(3);
            // Starve the serial side so the core fills up and stalls pixels
            if (p == 4)
            begin
                holdoff_request <= 1'b1;
                @(posedge clk);
                holdoff_request <= 1'b0;
            end
            drain_and_settle();
        end

        if (expected_bits.size() != 0)
        begin
            $error("%0d serial bits never arrived", expected_bits.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2400000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
src/plcs_pkg.sv
src/plcs_ifs.sv
src/plcs_row_cell.sv
src/plcs_serializer.sv
src/pwm_led_column_serializer_core.sv
tb/tb_pwm_led_column_serializer_core.sv
